### sv/brk_pkg.sv
// ----------------------------------------------------------------------------
// brk_pkg: shared definitions for the bracket sequence ranker
// Symbol codes, field widths and the ballot path count table contents.
// ----------------------------------------------------------------------------
package brk_pkg;

  localparam int MAX_HALF_LENGTH = 16;
  localparam int MAX_LEN         = 2 * MAX_HALF_LENGTH;
  localparam int TBL_ROWS        = MAX_LEN;        // remaining length 0 .. MAX_LEN-1
  localparam int TBL_COLS        = MAX_LEN + 1;    // depth 0 .. MAX_LEN
  localparam int RANK_W          = 42;
  localparam int BALLOT_W        = 26;
  localparam int HALF_W          = 5;
  localparam int DEPTH_W         = 6;
  localparam int POS_W           = 6;
  localparam int ROW_W           = $clog2(TBL_ROWS);
  localparam int COL_W           = $clog2(TBL_COLS);
  localparam int STACK_AW        = $clog2(MAX_HALF_LENGTH);
  localparam int SHIFT_W         = ROW_W - 1;

  typedef enum logic [1:0] {
    SYM_OPEN_ROUND   = 2'd0,
    SYM_CLOSE_ROUND  = 2'd1,
    SYM_OPEN_SQUARE  = 2'd2,
    SYM_CLOSE_SQUARE = 2'd3
  } symbol_t;

  typedef logic [TBL_ROWS-1:0][TBL_COLS-1:0][BALLOT_W-1:0] ballot_tbl_t;

  // Entry [i][j] counts one-type paths of i steps from depth j down to 0.
  function automatic ballot_tbl_t ballot_init();
    ballot_tbl_t tbl;
    logic [BALLOT_W-1:0] v;
    tbl = '0;
    tbl[0][0] = BALLOT_W'(1);
    for (int i = 1; i < TBL_ROWS; i++) begin
      for (int j = 0; j < TBL_COLS; j++) begin
        v = '0;
        if (j > 0) v = v + tbl[i-1][j-1];
        if (j + 1 < TBL_COLS) v = v + tbl[i-1][j+1];
        tbl[i][j] = v;
      end
    end
    return tbl;
  endfunction

endpackage

### sv/brk_if.sv
// ----------------------------------------------------------------------------
// brk_sym_if / brk_rank_if: valid-ready channels of the ranker
// One carries bracket symbols in, the other carries finished ranks out.
// ----------------------------------------------------------------------------
interface brk_sym_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface brk_rank_if;
  logic                      valid;
  logic                      ready;
  logic [brk_pkg::RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

### sv/brk_ballot_rom.sv
// ----------------------------------------------------------------------------
// brk_ballot_rom: ballot path count table with two registered read ports
// Both ports share the row (remaining length) and read separate depths.
// ----------------------------------------------------------------------------
module brk_ballot_rom (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brk_pkg::ROW_W-1:0]    row,
  input  logic [brk_pkg::COL_W-1:0]    col_a,
  input  logic [brk_pkg::COL_W-1:0]    col_b,
  output logic [brk_pkg::BALLOT_W-1:0] q_a,
  output logic [brk_pkg::BALLOT_W-1:0] q_b
);

  localparam brk_pkg::ballot_tbl_t BALLOT = brk_pkg::ballot_init();

  always_ff @(posedge clk) begin
    if (en) begin
      q_a <= BALLOT[row][col_a];
      q_b <= BALLOT[row][col_b];
    end
  end

endmodule

### sv/bracket_sequence_ranker.sv
// ----------------------------------------------------------------------------
// bracket_sequence_ranker: lexicographic rank of a two-type bracket sequence
// Symbols enter one per beat; the rank leaves after the last symbol.
// ----------------------------------------------------------------------------
// The block accepts one symbol per clock cycle while it is not stalled. For
// the last symbol of a sequence, the ballot table and the opener stack are
// read into registers, and the accumulate then adds the terms to the
// running rank and loads the sum into the output register. Depth and position
// advance as a symbol is accepted, so the next symbol never waits on them.
// A finished rank sits in an output register; while it is not taken, the
// block keeps accepting until the next final symbol reaches the accumulate
// stage. The half length register may only be written while the block is
// idle; zero counts as one pair and values above sixteen as sixteen.
module bracket_sequence_ranker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [brk_pkg::HALF_W-1:0] cfg_write_data,
  brk_sym_if.sink                    symbols,
  brk_rank_if.source                 ranks
);

  // Configuration and per-sequence state.
  logic [brk_pkg::HALF_W-1:0]  half_length;
  logic [brk_pkg::DEPTH_W-1:0] depth;
  logic [brk_pkg::POS_W-1:0]   position;
  logic [brk_pkg::RANK_W-1:0]  running_rank;
  logic                        stack_mem [brk_pkg::MAX_HALF_LENGTH];

  // Accumulate stage.
  logic                         acc_valid;
  logic                         acc_last;
  logic [1:0]                   acc_k1;
  logic                         acc_use2;
  logic [brk_pkg::SHIFT_W-1:0]  acc_sh1;
  logic [brk_pkg::SHIFT_W-1:0]  acc_sh2;
  logic                         stack_q;
  logic [brk_pkg::BALLOT_W-1:0] rom1_q;
  logic [brk_pkg::BALLOT_W-1:0] rom2_q;

  // Output register.
  logic                        out_valid;
  logic [brk_pkg::RANK_W-1:0]  out_rank;

  // Issue side.
  logic                         accept;
  logic                         acc_stall;
  logic [brk_pkg::HALF_W-1:0]   n_pairs;
  logic [brk_pkg::POS_W-1:0]    seq_len;
  logic                         last;
  logic [brk_pkg::POS_W-1:0]    r_full;
  logic [brk_pkg::ROW_W-1:0]    r;
  logic [brk_pkg::DEPTH_W:0]    j1;
  logic [brk_pkg::DEPTH_W-1:0]  j2;
  logic                         ok1;
  logic                         ok2;
  logic [brk_pkg::COL_W-1:0]    col1;
  logic [brk_pkg::COL_W-1:0]    col2;
  logic [brk_pkg::POS_W-1:0]    diff1;
  logic [brk_pkg::POS_W-1:0]    diff2;
  logic                         is_push;
  logic                         is_square;
  logic [1:0]                   k1;
  logic [brk_pkg::DEPTH_W-1:0]  depth_next;
  logic [brk_pkg::STACK_AW-1:0] top_addr;

  // Accumulate logic.
  logic [brk_pkg::RANK_W-1:0]   c1;
  logic [brk_pkg::RANK_W-1:0]   c2;
  logic [brk_pkg::RANK_W-1:0]   term1;
  logic [brk_pkg::RANK_W-1:0]   term2;
  logic [brk_pkg::RANK_W-1:0]   rank_sum;
  logic                         out_load;

  assign acc_stall     = acc_valid && acc_last && out_valid && !ranks.ready;
  assign symbols.ready = !acc_stall;
  assign accept        = symbols.valid && !acc_stall;

  always_comb begin
    if (half_length == '0) begin
      n_pairs = brk_pkg::HALF_W'(1);
    end else if (half_length > brk_pkg::HALF_W'(brk_pkg::MAX_HALF_LENGTH)) begin
      n_pairs = brk_pkg::HALF_W'(brk_pkg::MAX_HALF_LENGTH);
    end else begin
      n_pairs = half_length;
    end
  end

  assign seq_len = {n_pairs, 1'b0};
  assign last    = ({1'b0, position} + 7'd1) >= {1'b0, seq_len};
  assign r_full  = seq_len - brk_pkg::POS_W'(1) - position;
  assign r       = last ? '0 : r_full[brk_pkg::ROW_W-1:0];

  // A completion count is nonzero only when the target depth fits in what remains.
  assign j1    = {1'b0, depth} + 7'd1;
  assign j2    = depth - brk_pkg::DEPTH_W'(1);
  assign ok1   = j1 <= (brk_pkg::DEPTH_W + 1)'(r);
  assign ok2   = (depth != '0) && (j2 <= brk_pkg::DEPTH_W'(r));
  assign col1  = ok1 ? j1[brk_pkg::COL_W-1:0] : '0;
  assign col2  = ok2 ? j2[brk_pkg::COL_W-1:0] : '0;
  assign diff1 = brk_pkg::POS_W'(r) - brk_pkg::POS_W'(col1);
  assign diff2 = brk_pkg::POS_W'(r) - brk_pkg::POS_W'(col2);

  assign is_push   = (symbols.symbol == brk_pkg::SYM_OPEN_ROUND) ||
                     (symbols.symbol == brk_pkg::SYM_OPEN_SQUARE);
  assign is_square = symbols.symbol inside {brk_pkg::SYM_OPEN_SQUARE,
                                            brk_pkg::SYM_CLOSE_SQUARE};
  assign top_addr  = j2[brk_pkg::STACK_AW-1:0];

  always_comb begin
    case (symbols.symbol)
      brk_pkg::SYM_OPEN_ROUND:   k1 = 2'd0;
      brk_pkg::SYM_CLOSE_ROUND:  k1 = 2'd1;
      brk_pkg::SYM_OPEN_SQUARE:  k1 = 2'd1;
      brk_pkg::SYM_CLOSE_SQUARE: k1 = 2'd2;
      default:                   k1 = 2'd0;
    endcase
    if (!ok1) k1 = 2'd0;
  end

  always_comb begin
    depth_next = depth;
    if (is_push) begin
      if (depth != '1) depth_next = depth + brk_pkg::DEPTH_W'(1);
    end else begin
      if (depth != '0) depth_next = depth - brk_pkg::DEPTH_W'(1);
    end
    if (last) depth_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= brk_pkg::HALF_W'(1);
    end else if (cfg_write_en) begin
      half_length <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      position <= '0;
    end else if (accept) begin
      depth    <= depth_next;
      position <= last ? '0 : position + brk_pkg::POS_W'(1);
    end
  end

  // Opener stack. A push writes the entry at the current depth; the top read
  // for the same symbol looks one entry below, and a following symbol reads
  // only after the write has landed.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_push && depth < brk_pkg::DEPTH_W'(brk_pkg::MAX_HALF_LENGTH)) begin
        stack_mem[depth[brk_pkg::STACK_AW-1:0]] <= is_square;
      end
      stack_q <= stack_mem[top_addr];
    end
  end

  brk_ballot_rom u_rom (
    .clk   (clk),
    .en    (accept),
    .row   (r),
    .col_a (col1),
    .col_b (col2),
    .q_a   (rom1_q),
    .q_b   (rom2_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (!acc_stall) begin
      acc_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_last <= last;
      acc_k1   <= k1;
      // Above the stored stack depth the top counts as a square opener.
      acc_use2 <= is_square && ok2 &&
                  (depth <= brk_pkg::DEPTH_W'(brk_pkg::MAX_HALF_LENGTH));
      acc_sh1  <= diff1[brk_pkg::SHIFT_W:1];
      acc_sh2  <= diff2[brk_pkg::SHIFT_W:1];
    end
  end

  assign c1       = brk_pkg::RANK_W'(rom1_q) << acc_sh1;
  assign c2       = brk_pkg::RANK_W'(rom2_q) << acc_sh2;
  assign term1    = (acc_k1 == 2'd2) ? (c1 << 1) : ((acc_k1 == 2'd1) ? c1 : '0);
  assign term2    = (acc_use2 && !stack_q) ? c2 : '0;
  assign rank_sum = running_rank + term1 + term2;
  assign out_load = acc_valid && acc_last && !acc_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_rank <= '0;
    end else if (acc_valid && !acc_stall) begin
      running_rank <= acc_last ? '0 : rank_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !ranks.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_rank <= rank_sum;
  end

  assign ranks.valid = out_valid;
  assign ranks.rank  = out_rank;

endmodule

### tb/sv/bracket_sequence_ranker_test.sv
// ----------------------------------------------------------------------------
// bracket_sequence_ranker_test: self-checking bench for the sequence ranker
// Feeds bracket symbols through a bursty valid-ready channel and checks each
// rank that comes back against a cycle-free model of the ranking rules. The
// run is a short table of directed cases, then random phases over many pair
// counts with the sink stalling on changing patterns and long hold-offs.
// ----------------------------------------------------------------------------
module bracket_sequence_ranker_test;

  localparam bit [63:0] RANK_MASK   = (64'd1 << brk_pkg::RANK_W) - 64'd1;
  localparam int        HOLD_CYCLES = 80;
  localparam int        SYMBOL_GOAL = 1200;

  typedef enum bit {ROW_LEN, ROW_SYM} row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    brk_pkg::symbol_t            sym;
    bit [brk_pkg::HALF_W-1:0]    half;
    bit                          typed;
    bit [brk_pkg::RANK_W-1:0]    rank;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write_en;
  logic [brk_pkg::HALF_W-1:0]  cfg_write_data;

  brk_sym_if  sym_ch ();
  brk_rank_if rank_ch ();

  bracket_sequence_ranker u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .symbols        (sym_ch.sink),
    .ranks          (rank_ch.source)
  );

  always #2 clk = ~clk;

  // Ranking model state.
  bit [63:0]                 ballot_paths [0:brk_pkg::MAX_LEN][0:brk_pkg::MAX_LEN];
  bit                        pred_openers [0:brk_pkg::MAX_HALF_LENGTH-1];
  int unsigned               pred_depth;
  int unsigned               pred_pos;
  bit [brk_pkg::RANK_W-1:0]  pred_rank;
  bit [brk_pkg::HALF_W-1:0]  pred_half;

  bit [brk_pkg::RANK_W-1:0]  pending_ranks [$];
  brk_pkg::symbol_t          seq_q [$];

  int               errors;
  int               ranks_checked;
  int               syms_sent;
  int               lengths_set;
  int               burst_left;
  bit               send_gaps;

  // Sink side controls.
  int               hold_reqs;
  int               holds_done;
  int               hold_left;
  bit [1:0]         recv_mode;
  bit [31:0]        recv_cycle;
  bit [15:0]        recv_pat = 16'hffff;

  // Completions of r remaining symbols from depth j, scaled by the free
  // choice of bracket type for every pair still to be placed.
  function automatic bit [63:0] completions_of(int unsigned r, int unsigned j);
    if (j > r || r > brk_pkg::MAX_LEN || j > brk_pkg::MAX_LEN) return 64'd0;
    return (ballot_paths[r][j] << ((r - j) >> 1)) & RANK_MASK;
  endfunction

  function automatic void push_kind(bit k);
    if (pred_depth < brk_pkg::MAX_HALF_LENGTH) pred_openers[pred_depth] = k;
    if (pred_depth < 63) pred_depth++;
  endfunction

  function automatic bit rank_symbol(input brk_pkg::symbol_t s,
                                     output bit [brk_pkg::RANK_W-1:0] rk);
    int unsigned eff;
    int unsigned len;
    int unsigned r;
    int unsigned l;
    bit          top;
    eff = (pred_half == 0) ? 1 :
          ((pred_half > brk_pkg::MAX_HALF_LENGTH) ? brk_pkg::MAX_HALF_LENGTH : pred_half);
    len = 2 * eff;
    r = (pred_pos + 1 < len) ? len - 1 - pred_pos : 0;
    l = pred_depth;
    rk = '0;
    if (s == brk_pkg::SYM_OPEN_ROUND) begin
      push_kind(1'b0);
    end else begin
      pred_rank = pred_rank + brk_pkg::RANK_W'(completions_of(r, l + 1));
      if (s == brk_pkg::SYM_CLOSE_ROUND) begin
        if (pred_depth > 0) pred_depth--;
      end else begin
        // Above the stack's reach the opener on top reads as square.
        top = 1'b1;
        if (l > 0 && l <= brk_pkg::MAX_HALF_LENGTH) top = pred_openers[l-1];
        if (l > 0 && !top) begin
          pred_rank = pred_rank + brk_pkg::RANK_W'(completions_of(r, l - 1));
        end
        if (s == brk_pkg::SYM_OPEN_SQUARE) begin
          push_kind(1'b1);
        end else begin
          pred_rank = pred_rank + brk_pkg::RANK_W'(completions_of(r, l + 1));
          if (pred_depth > 0) pred_depth--;
        end
      end
    end
    if (pred_pos + 1 >= len) begin
      rk = pred_rank;
      pred_rank = '0;
      pred_depth = 0;
      pred_pos = 0;
      return 1'b1;
    end
    pred_pos++;
    return 1'b0;
  endfunction

  task automatic send_symbol(input brk_pkg::symbol_t s, input bit typed,
                             input bit [brk_pkg::RANK_W-1:0] typed_rank);
    int                        gap;
    bit [brk_pkg::RANK_W-1:0]  rk;
    if (burst_left == 0) begin
      gap = send_gaps ? $urandom_range(0, 8) : 0;
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        sym_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= s;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    syms_sent++;
    if (rank_symbol(s, rk)) pending_ranks = {pending_ranks, (typed ? typed_rank : rk)};
  endtask

  task automatic wait_all_ranks();
    sym_ch.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    // A symbol that ends no sequence may still be in the pipeline.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_half_length(input bit [brk_pkg::HALF_W-1:0] v);
    wait_all_ranks();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pred_half = v;
    lengths_set++;
  endtask

  task automatic gen_sequence(input int n);
    int kind;
    int d;
    int total;
    int heavy;
    bit t;
    bit stk [brk_pkg::MAX_LEN];
    seq_q.delete();
    total = 2 * n;
    kind = $urandom_range(0, 99);
    d = 0;
    if (kind < 5) begin
      repeat (n) seq_q = {seq_q, brk_pkg::SYM_OPEN_ROUND};
      repeat (n) seq_q = {seq_q, brk_pkg::SYM_CLOSE_ROUND};
    end else if (kind < 10) begin
      repeat (n) begin
        seq_q = {seq_q, brk_pkg::SYM_OPEN_SQUARE};
        seq_q = {seq_q, brk_pkg::SYM_CLOSE_SQUARE};
      end
    end else if (kind < 20) begin
      // Broken sequences; at full length they may open past the stack depth.
      heavy = (n == brk_pkg::MAX_HALF_LENGTH) ? $urandom_range(17, 24) : 0;
      for (int p = 0; p < total; p++) begin
        if (p < heavy) begin
          seq_q = {seq_q, brk_pkg::symbol_t'({1'($urandom_range(0, 1)), 1'b0})};
        end else begin
          seq_q = {seq_q, brk_pkg::symbol_t'(2'($urandom_range(0, 3)))};
        end
      end
    end else begin
      for (int p = 0; p < total; p++) begin
        if (d + 2 <= total - p && (d == 0 || $urandom_range(0, 1) == 1)) begin
          t = 1'($urandom_range(0, 1));
          stk[d] = t;
          d++;
          seq_q = {seq_q, (t ? brk_pkg::SYM_OPEN_SQUARE : brk_pkg::SYM_OPEN_ROUND)};
        end else begin
          d--;
          t = stk[d];
          seq_q = {seq_q, (t ? brk_pkg::SYM_CLOSE_SQUARE : brk_pkg::SYM_CLOSE_ROUND)};
        end
      end
    end
  endtask

  // Sink: long hold-offs on request, otherwise always ready or a rotating
  // stall pattern that is redrawn whenever the low six bits of the cycle counter are zero.
  always @(posedge clk) begin
    recv_cycle <= recv_cycle + 1;
    if (rst) begin
      rank_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rank_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_done) begin
      rank_ch.ready <= 1'b0;
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end else if (recv_mode == 0) begin
      rank_ch.ready <= 1'b1;
    end else begin
      rank_ch.ready <= recv_pat[recv_cycle[3:0]];
      if (recv_cycle[5:0] == 0) recv_pat <= 16'($urandom) | 16'h0101;
    end
  end

  always @(posedge clk) begin
    if (!rst && rank_ch.valid && rank_ch.ready) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: rank beat with none expected: expected none, actual %0d",
                 $time, rank_ch.rank);
        errors++;
      end else begin
        if (rank_ch.rank !== pending_ranks[0]) begin
          $display("%0t: rank mismatch: expected %0d, actual %0d",
                   $time, pending_ranks[0], rank_ch.rank);
          errors++;
        end
        void'(pending_ranks.pop_front());
        ranks_checked++;
      end
    end
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t                 dir_rows [31];
    int                        first_lengths [7];
    bit [brk_pkg::HALF_W-1:0]  len_val;
    int                        eff;
    int                        nseq;
    int                        k;
    int                        phase;

    sym_ch.valid   = 1'b0;
    sym_ch.symbol  = 2'd0;
    rank_ch.ready  = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    recv_mode      = 2'd1;
    send_gaps      = 1'b1;

    for (int r = 0; r <= brk_pkg::MAX_LEN; r++) begin
      for (int j = 0; j <= brk_pkg::MAX_LEN; j++) begin
        if (r == 0) ballot_paths[r][j] = (j == 0) ? 64'd1 : 64'd0;
        else ballot_paths[r][j] = ((j > 0) ? ballot_paths[r-1][j-1] : 64'd0)
                                + ((j < brk_pkg::MAX_LEN) ? ballot_paths[r-1][j+1] : 64'd0);
      end
    end
    foreach (pred_openers[i]) pred_openers[i] = 1'b0;
    pred_depth = 0;
    pred_pos   = 0;
    pred_rank  = '0;
    pred_half  = 5'd1;

    // One pair after reset, then zero pairs (read as one), three pairs with
    // the smallest and largest ranks, and a length cut short mid-sequence.
    dir_rows = '{
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b1, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b1, 42'd1},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_LEN, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b1, 42'd1},
      '{ROW_LEN, brk_pkg::SYM_OPEN_ROUND,   5'd3, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b1, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b1, 42'd39},
      '{ROW_LEN, brk_pkg::SYM_OPEN_ROUND,   5'd2, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_SQUARE, 5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_SQUARE,  5'd0, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_OPEN_ROUND,   5'd0, 1'b0, 42'd0},
      '{ROW_LEN, brk_pkg::SYM_OPEN_ROUND,   5'd1, 1'b0, 42'd0},
      '{ROW_SYM, brk_pkg::SYM_CLOSE_ROUND,  5'd0, 1'b0, 42'd0}
    };
    first_lengths = '{16, 31, 2, 1, 0, 17, 4};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) write_half_length(dir_rows[i].half);
      else send_symbol(dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].rank);
    end

    phase = 0;
    while (syms_sent < SYMBOL_GOAL) begin
      if (phase < 7) len_val = brk_pkg::HALF_W'(first_lengths[phase]);
      else if ($urandom_range(0, 9) < 8) len_val = brk_pkg::HALF_W'($urandom_range(1, 5));
      else len_val = brk_pkg::HALF_W'($urandom_range(0, 31));
      write_half_length(len_val);
      // A phase may have left a sequence open; finish it under the new length.
      while (pred_pos != 0) begin
        send_symbol(brk_pkg::symbol_t'(2'($urandom_range(0, 3))), 1'b0, '0);
      end

      eff = (len_val == 0) ? 1 :
            ((len_val > brk_pkg::MAX_HALF_LENGTH) ? brk_pkg::MAX_HALF_LENGTH : len_val);
      recv_mode <= 2'($urandom_range(0, 2));
      send_gaps = ($urandom_range(0, 3) != 0);
      if (eff <= 2 && (phase == 2 || $urandom_range(0, 1) == 1)) begin
        // Sink holds off while short sequences keep coming, so the block fills.
        hold_reqs <= hold_reqs + 1;
        send_gaps = 1'b0;
      end

      nseq = (eff >= 12) ? $urandom_range(2, 4) : $urandom_range(4, 16);
      repeat (nseq) begin
        gen_sequence(eff);
        foreach (seq_q[i]) send_symbol(seq_q[i], 1'b0, '0);
      end
      if ($urandom_range(0, 2) == 0) begin
        gen_sequence(eff);
        k = $urandom_range(1, 2 * eff - 1);
        for (int i = 0; i < k; i++) send_symbol(seq_q[i], 1'b0, '0);
      end
      phase++;
    end

    sym_ch.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d symbols over %0d half length settings; checked %0d ranks.",
             syms_sent, lengths_set, ranks_checked);
    $display("The sink held off %0d times; %0d mismatches seen.", holds_done, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
